// File: hw/rtl/lruk_pkg.sv
// ----------------------------------------------------------------------------
// lruk_pkg: shared types and constants of the LRU-K frame replacer
// Payload structs, operation and status codes, and list engine control.
// ----------------------------------------------------------------------------
package lruk_pkg;

  localparam int MaxFrames = 64;
  localparam int FrameW    = $clog2(MaxFrames);
  localparam int CountW    = $clog2(MaxFrames + 1);
  localparam int HitW      = 4;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 7;

  localparam logic [HitW-1:0]   KReset      = 4'd2;
  localparam logic [CountW-1:0] FramesReset = CountW'(MaxFrames);

  localparam logic [CfgIdxW-1:0] CFG_HISTORY_DEPTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_FRAMES_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    OP_RECORD    = 2'd0,
    OP_SET_EVICT = 2'd1,
    OP_REMOVE    = 2'd2,
    OP_EVICT     = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_RANGE         = 2'd1,
    ST_NOT_EVICTABLE = 2'd2,
    ST_NO_VICTIM     = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [FrameW-1:0] frame_index;
    logic              evictable_flag;
  } lruk_in_t;

  typedef struct packed {
    status_e           status;
    logic [FrameW-1:0] victim_frame;
    logic [CountW-1:0] evictable_total;
  } lruk_out_t;

  // command to the list engine: scan pass (find and delete) or append
  typedef struct packed {
    logic              scan;
    logic              append;
    logic              sel;      // 0 young list, 1 old list
    logic              by_mark;  // match on evictable mark instead of frame
    logic [FrameW-1:0] frame;
  } lruk_cmd_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [FrameW-1:0] victim;
  } lruk_eng_t;

endpackage

// File: hw/rtl/lru_k_frame_replacer.sv
// ----------------------------------------------------------------------------
// lru_k_frame_replacer: LRU-K victim chooser for buffer frames
// Tracks per-frame hit counts and evictable marks, keeps young and old
// frame lists, and answers record, set evictable, remove and evict.
// ----------------------------------------------------------------------------
// Flow: set evictable and rejected frames go from the read state straight to
// the result state; record and remove walk the list that holds the frame when
// it must move or leave; evict walks the young list and then, if no victim
// is found there, the old list (a frame sits in one list at most).
// Throughput: one operation at a time; the list engine walks its list memory
// one entry per cycle.
// Reset: control state, counts and marks clear at once; no clearing pass.
module lru_k_frame_replacer
  import lruk_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lruk_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lruk_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_DEL  = 7'b0000100,
    S_APP  = 7'b0001000,
    S_EVY  = 7'b0010000,
    S_EVO  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [HitW-1:0]      k_q;
  logic [CountW-1:0]    frames_q;
  opcode_e              op_q;
  logic [FrameW-1:0]    f_q;
  logic                 flag_q;
  logic [HitW-1:0]      hc_rd_q;
  logic [HitW-1:0]      hc_mem [MaxFrames];
  logic [MaxFrames-1:0] tracked_q;
  logic [MaxFrames-1:0] mark_q;
  logic [MaxFrames-1:0] in_old_q;
  logic [CountW-1:0]    evict_cnt_q;
  status_e              status_q;
  logic [FrameW-1:0]    victim_q;
  logic                 app_sel_q;
  logic                 out_valid_q;
  lruk_out_t            out_q;

  lruk_cmd_t eng_cmd;
  lruk_eng_t eng_stat;

  logic            in_fire;
  logic            cfg_fire;
  logic            cur_tracked;
  logic            cur_old;
  logic            cur_mark;
  logic [HitW-1:0] cnt;
  logic [HitW-1:0] k_eff;
  logic [HitW-1:0] c_new;
  logic            to_old;
  logic            need_move;
  logic            range_err;
  logic            out_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  assign cur_tracked = tracked_q[f_q];
  assign cur_old     = in_old_q[f_q];
  assign cur_mark    = mark_q[f_q];
  assign cnt         = cur_tracked ? hc_rd_q : '0;
  assign k_eff       = (k_q == '0) ? HitW'(1) : k_q;
  assign c_new       = (cnt >= k_eff) ? k_eff : HitW'(cnt + 1'b1);
  assign to_old      = (c_new >= k_eff);
  // a young frame that stays young keeps its place
  assign need_move   = to_old || !cur_tracked || cur_old;
  assign range_err   = ({1'b0, f_q} >= frames_q);
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  lruk_list_engine u_list (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (eng_cmd),
    .mark_i (mark_q),
    .stat_o (eng_stat)
  );

  always_comb begin
    state_d         = state_q;
    eng_cmd         = '0;
    eng_cmd.frame   = f_q;
    eng_cmd.sel     = cur_old;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (op_q == OP_EVICT) begin
          eng_cmd.scan    = 1'b1;
          eng_cmd.sel     = 1'b0;
          eng_cmd.by_mark = 1'b1;
          state_d         = S_EVY;
        end else if (range_err) begin
          state_d = S_OUT;
        end else if (op_q == OP_RECORD) begin
          if (!need_move) begin
            state_d = S_OUT;
          end else if (cur_tracked) begin
            eng_cmd.scan = 1'b1;
            state_d      = S_DEL;
          end else begin
            state_d = S_APP;
          end
        end else if (op_q == OP_REMOVE) begin
          if (cur_tracked && cur_mark) begin
            eng_cmd.scan = 1'b1;
            state_d      = S_DEL;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          state_d = S_OUT;
        end
      end
      S_DEL: begin
        if (eng_stat.done) begin
          state_d = (op_q == OP_RECORD) ? S_APP : S_OUT;
        end
      end
      S_APP: begin
        eng_cmd.append = 1'b1;
        eng_cmd.sel    = app_sel_q;
        state_d        = S_OUT;
      end
      S_EVY: begin
        if (eng_stat.done) begin
          if (eng_stat.found) begin
            state_d = S_OUT;
          end else begin
            eng_cmd.scan    = 1'b1;
            eng_cmd.sel     = 1'b1;
            eng_cmd.by_mark = 1'b1;
            state_d         = S_EVO;
          end
        end
      end
      S_EVO: begin
        if (eng_stat.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // hit count memory: reads at transfer, entries behind tracked_q
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hc_rd_q <= hc_mem[in_data_i.frame_index];
    end
    if (state_q == S_READ && op_q == OP_RECORD && !range_err) begin
      hc_mem[f_q] <= c_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= KReset;
      frames_q    <= FramesReset;
      op_q        <= OP_RECORD;
      f_q         <= '0;
      flag_q      <= 1'b0;
      tracked_q   <= '0;
      mark_q      <= '0;
      in_old_q    <= '0;
      evict_cnt_q <= '0;
      status_q    <= ST_OK;
      victim_q    <= '0;
      app_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_HISTORY_DEPTH: k_q      <= cfg_data_i[HitW-1:0];
          CFG_FRAMES_IN_USE: frames_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        op_q     <= in_data_i.opcode;
        f_q      <= in_data_i.frame_index;
        flag_q   <= in_data_i.evictable_flag;
        status_q <= ST_OK;
        victim_q <= '0;
      end

      if (state_q == S_READ && op_q != OP_EVICT) begin
        if (range_err) begin
          status_q <= ST_RANGE;
        end else begin
          case (op_q)
            OP_RECORD: begin
              tracked_q[f_q] <= 1'b1;
              app_sel_q      <= to_old;
              if (need_move) begin
                in_old_q[f_q] <= to_old;
              end
            end
            OP_SET_EVICT: begin
              if (cur_tracked) begin
                if (!cur_mark && flag_q) begin
                  evict_cnt_q <= evict_cnt_q + 1'b1;
                end
                if (cur_mark && !flag_q && evict_cnt_q != '0) begin
                  evict_cnt_q <= evict_cnt_q - 1'b1;
                end
                mark_q[f_q] <= flag_q;
              end
            end
            OP_REMOVE: begin
              if (cur_tracked) begin
                if (!cur_mark) begin
                  status_q <= ST_NOT_EVICTABLE;
                end else begin
                  tracked_q[f_q] <= 1'b0;
                  mark_q[f_q]    <= 1'b0;
                  if (evict_cnt_q != '0) begin
                    evict_cnt_q <= evict_cnt_q - 1'b1;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end

      // the engine already dropped the victim from its list
      if ((state_q == S_EVY || state_q == S_EVO) && eng_stat.done) begin
        if (eng_stat.found) begin
          victim_q                  <= eng_stat.victim;
          tracked_q[eng_stat.victim] <= 1'b0;
          mark_q[eng_stat.victim]    <= 1'b0;
          if (evict_cnt_q != '0) begin
            evict_cnt_q <= evict_cnt_q - 1'b1;
          end
        end else if (state_q == S_EVO) begin
          status_q <= ST_NO_VICTIM;
        end
      end

      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q           <= 1'b1;
        out_q.status          <= status_q;
        out_q.victim_frame    <= victim_q;
        out_q.evictable_total <= evict_cnt_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_stat.done |-> (state_q == S_DEL || state_q == S_EVY || state_q == S_EVO))
    else $error("list engine finished while sequencer was not waiting");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict_cnt_q <= CountW'(MaxFrames))
    else $error("evictable count above frame count");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_valid_q) |=> out_valid_o)
    else $error("result not presented after finishing an operation");

  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_cmd.scan |-> (state_q == S_READ || state_q == S_EVY))
    else $error("list scan started outside of a dispatch state");

endmodule

// File: hw/rtl/lruk_list_engine.sv
// ----------------------------------------------------------------------------
// lruk_list_engine: ordered frame lists of the LRU-K replacer
// Holds the young and old lists in one memory and walks them one entry per
// cycle, finding a frame or the first evictable one and closing the gap.
// ----------------------------------------------------------------------------
module lruk_list_engine
  import lruk_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lruk_cmd_t            cmd_i,
  input  logic [MaxFrames-1:0] mark_i,
  output lruk_eng_t            stat_o
);

  localparam int AddrW = FrameW + 1;

  logic [FrameW-1:0] order_mem [2*MaxFrames];

  logic [CountW-1:0] len_q [2];
  logic              busy_q;
  logic              sel_q;
  logic              by_mark_q;
  logic [FrameW-1:0] frame_q;
  logic [CountW-1:0] idx_q;
  logic              rd_valid_q;
  logic [FrameW-1:0] rd_idx_q;
  logic [FrameW-1:0] rd_data_q;
  logic              found_q;
  logic [FrameW-1:0] victim_q;
  logic              done_q;

  logic [CountW-1:0] cur_len;
  logic              rd_en;
  logic              match;
  logic              shift_we;
  logic              finish;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  shift_addr;
  logic [AddrW-1:0]  app_addr;
  logic [FrameW-1:0] prev_idx;
  logic [CountW-1:0] app_len;

  assign cur_len    = len_q[sel_q];
  assign rd_en      = busy_q && (idx_q < cur_len);
  assign match      = by_mark_q ? mark_i[rd_data_q] : (rd_data_q == frame_q);
  assign shift_we   = rd_valid_q && found_q;
  assign finish     = busy_q && !rd_en && !rd_valid_q;
  assign prev_idx   = rd_idx_q - 1'b1;
  assign app_len    = len_q[cmd_i.sel];
  assign rd_addr    = {sel_q, idx_q[FrameW-1:0]};
  assign shift_addr = {sel_q, prev_idx};
  assign app_addr   = {cmd_i.sel, app_len[FrameW-1:0]};

  // entries behind the match move one place toward the head
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= order_mem[rd_addr];
    end
    if (shift_we) begin
      order_mem[shift_addr] <= rd_data_q;
    end else if (cmd_i.append) begin
      order_mem[app_addr] <= cmd_i.frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q[0]   <= '0;
      len_q[1]   <= '0;
      busy_q     <= 1'b0;
      sel_q      <= 1'b0;
      by_mark_q  <= 1'b0;
      frame_q    <= '0;
      idx_q      <= '0;
      rd_valid_q <= 1'b0;
      rd_idx_q   <= '0;
      found_q    <= 1'b0;
      victim_q   <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.scan) begin
        busy_q     <= 1'b1;
        sel_q      <= cmd_i.sel;
        by_mark_q  <= cmd_i.by_mark;
        frame_q    <= cmd_i.frame;
        idx_q      <= '0;
        rd_valid_q <= 1'b0;
        found_q    <= 1'b0;
      end else if (busy_q) begin
        if (rd_en) begin
          idx_q <= idx_q + 1'b1;
        end
        rd_valid_q <= rd_en;
        rd_idx_q   <= idx_q[FrameW-1:0];
        if (rd_valid_q && !found_q && match) begin
          found_q  <= 1'b1;
          victim_q <= rd_data_q;
        end
        if (finish) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          if (found_q) begin
            len_q[sel_q] <= cur_len - 1'b1;
          end
        end
      end
      if (cmd_i.append) begin
        len_q[cmd_i.sel] <= app_len + 1'b1;
      end
    end
  end

  assign stat_o.done   = done_q;
  assign stat_o.found  = found_q;
  assign stat_o.victim = victim_q;

endmodule
